FILE: rtl/core/mi3_pkg.sv
// shared widths, beat types and cofactor index table for the 3x3 inverse
package mi3_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// product, cofactor, det partial product, det term, det widths
	localparam int PW   = 2 * DATA_WIDTH;
	localparam int AW   = PW + 1;
	localparam int HPW  = 2 * DATA_WIDTH + 1;
	localparam int TW   = 3 * DATA_WIDTH + 1;
	localparam int DETW = 3 * DATA_WIDTH + 3;

	// scaled numerator and divider compare widths
	localparam int NW = AW + 2 * FRAC_BITS;
	localparam int HW = NW - DATA_WIDTH;
	localparam int CW = (HW > DETW) ? HW : DETW;

	// register stages from input to output
	localparam int NST = DATA_WIDTH + 8;

	// cofactor k = m[a]*m[b] - m[c]*m[d], row-major element index
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 5, 7},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{2, 3, 0, 5},
		'{3, 7, 4, 6},
		'{1, 6, 0, 7},
		'{0, 4, 1, 3}
	};

	// cofactors used in the row 0 expansion of the determinant
	localparam int DET_IDX [3] = '{0, 3, 6};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] in_r0_c0;
		logic signed [DATA_WIDTH-1:0] in_r0_c1;
		logic signed [DATA_WIDTH-1:0] in_r0_c2;
		logic signed [DATA_WIDTH-1:0] in_r1_c0;
		logic signed [DATA_WIDTH-1:0] in_r1_c1;
		logic signed [DATA_WIDTH-1:0] in_r1_c2;
		logic signed [DATA_WIDTH-1:0] in_r2_c0;
		logic signed [DATA_WIDTH-1:0] in_r2_c1;
		logic signed [DATA_WIDTH-1:0] in_r2_c2;
	} mat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] inv_r0_c0;
		logic signed [DATA_WIDTH-1:0] inv_r0_c1;
		logic signed [DATA_WIDTH-1:0] inv_r0_c2;
		logic signed [DATA_WIDTH-1:0] inv_r1_c0;
		logic signed [DATA_WIDTH-1:0] inv_r1_c1;
		logic signed [DATA_WIDTH-1:0] inv_r1_c2;
		logic signed [DATA_WIDTH-1:0] inv_r2_c0;
		logic signed [DATA_WIDTH-1:0] inv_r2_c1;
		logic signed [DATA_WIDTH-1:0] inv_r2_c2;
		logic                         singular;
	} inv_t;

endpackage

FILE: rtl/core/mi3_div.sv
// one pipelined restoring divider lane with sign and saturation
module mi3_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [mi3_pkg::AW-1:0]        num_mag,
	input  logic                          num_neg,
	input  logic [mi3_pkg::DETW-1:0]      den_mag,
	input  logic                          den_neg,
	input  logic                          clr,
	output logic [mi3_pkg::DATA_WIDTH-1:0] quo
);
	import mi3_pkg::*;

	logic [NW-1:0]         num_sh;
	logic [CW-1:0]         hi_c;
	logic [CW-1:0]         den_c;

	logic [DETW-1:0]       rem_s [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo_s [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] low_s [0:DATA_WIDTH];
	logic [DETW-1:0]       den_s [0:DATA_WIDTH];
	logic                  big_s [0:DATA_WIDTH];
	logic                  neg_s [0:DATA_WIDTH];

	logic [DATA_WIDTH-1:0] lim;
	logic [DATA_WIDTH-1:0] mag;
	logic [DATA_WIDTH-1:0] val;
	logic [DATA_WIDTH-1:0] res_s;

	// numerator scaled by two fraction widths, split at the quotient width
	assign num_sh = NW'(num_mag) << (2 * FRAC_BITS);
	assign hi_c   = CW'(num_sh[NW-1:DATA_WIDTH]);
	assign den_c  = CW'(den_mag);

	// entry stage: overflow check and initial partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			big_s[0] <= (hi_c >= den_c);
			rem_s[0] <= hi_c[DETW-1:0];
			quo_s[0] <= '0;
			low_s[0] <= num_sh[DATA_WIDTH-1:0];
			den_s[0] <= den_mag;
			neg_s[0] <= num_neg ^ den_neg;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar g = 1; g <= DATA_WIDTH; g++) begin : g_step
		logic [DETW:0] trial;
		logic [DETW:0] diff;
		assign trial = {rem_s[g-1], low_s[g-1][DATA_WIDTH-1]};
		assign diff  = trial - {1'b0, den_s[g-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, den_s[g-1]}) begin
					rem_s[g] <= diff[DETW-1:0];
					quo_s[g] <= {quo_s[g-1][DATA_WIDTH-2:0], 1'b1};
				end else begin
					rem_s[g] <= trial[DETW-1:0];
					quo_s[g] <= {quo_s[g-1][DATA_WIDTH-2:0], 1'b0};
				end
				low_s[g] <= {low_s[g-1][DATA_WIDTH-2:0], 1'b0};
				den_s[g] <= den_s[g-1];
				big_s[g] <= big_s[g-1];
				neg_s[g] <= neg_s[g-1];
			end
		end
	end

	// clamp magnitude to the signed range, then apply the sign
	always_comb begin
		lim = neg_s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
		                        : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		mag = (big_s[DATA_WIDTH] || (quo_s[DATA_WIDTH] > lim)) ? lim : quo_s[DATA_WIDTH];
		val = neg_s[DATA_WIDTH] ? (~mag + 1'b1) : mag;
	end

	// output register, cleared for a singular matrix
	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= clr ? '0 : val;
		end
	end

	assign quo = res_s;

endmodule

FILE: rtl/core/matrix3_inverse.sv
// 3x3 matrix inverse by the adjugate, signed fixed point, fully pipelined
//
// Input channel mat_valid / mat_stall / mat carries one 3x3 matrix per beat,
// nine signed Q16.16 elements. Output channel inv_valid / inv_stall / inv
// carries the nine inverse elements, truncated toward zero and saturated to
// Q16.16, plus a singular flag. A singular matrix gives all-zero elements.
// A beat is taken at a rising edge with valid high and stall low.
//
// The pipeline has six stages for the cofactor products, cofactors,
// determinant partial products, terms, sum and magnitudes, then nine
// divider lanes of one entry stage, one stage per quotient bit and one
// saturation stage. It takes one matrix per cycle while mat_stall is low.
//
// When inv_stall is high while a result waits, the whole pipeline holds
// and mat_stall rises in the same cycle; nothing is dropped or repeated.
// arst_n clears all valid bits; the pipeline is empty after reset.
module matrix3_inverse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_stall,
	input  mi3_pkg::mat_t mat,
	output logic          inv_valid,
	input  logic          inv_stall,
	output mi3_pkg::inv_t inv
);
	import mi3_pkg::*;

	logic                         en;
	logic                         v_s [1:NST];

	logic signed [DATA_WIDTH-1:0] m_a [9];

	logic signed [PW-1:0]         prod_s1 [18];
	logic signed [DATA_WIDTH-1:0] mtop_s1 [3];
	logic signed [DATA_WIDTH-1:0] mtop_s2 [3];
	logic signed [AW-1:0]         adj_s2  [9];
	logic signed [AW-1:0]         adj_s3  [9];
	logic signed [AW-1:0]         adj_s4  [9];
	logic signed [AW-1:0]         adj_s5  [9];
	logic signed [HPW-1:0]        pl_s3   [3];
	logic signed [HPW-1:0]        ph_s3   [3];
	logic signed [TW-1:0]         term_s4 [3];
	logic signed [DETW-1:0]       det_s5;

	logic                         dneg_s6;
	logic                         dzero_s6;
	logic [DETW-1:0]              dmag_s6;
	logic                         nneg_s6 [9];
	logic [AW-1:0]                nmag_s6 [9];

	logic                         zero_s  [1:DATA_WIDTH+2];
	logic [DATA_WIDTH-1:0]        quo     [9];

	// global advance: hold only when a finished result is stalled
	assign en        = !(v_s[NST] && inv_stall);
	assign mat_stall = !en;
	assign inv_valid = v_s[NST];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= NST; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			v_s[1] <= mat_valid;
			for (int j = 2; j <= NST; j++) v_s[j] <= v_s[j-1];
		end
	end

	// unpack the beat into row-major elements
	always_comb begin
		m_a[0] = mat.in_r0_c0;
		m_a[1] = mat.in_r0_c1;
		m_a[2] = mat.in_r0_c2;
		m_a[3] = mat.in_r1_c0;
		m_a[4] = mat.in_r1_c1;
		m_a[5] = mat.in_r1_c2;
		m_a[6] = mat.in_r2_c0;
		m_a[7] = mat.in_r2_c1;
		m_a[8] = mat.in_r2_c2;
	end

	// stages 1 and 2: cofactor products, then cofactor differences
	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[2*k]   <= m_a[COF_IDX[k][0]] * m_a[COF_IDX[k][1]];
				prod_s1[2*k+1] <= m_a[COF_IDX[k][2]] * m_a[COF_IDX[k][3]];
				adj_s2[k]      <= AW'(prod_s1[2*k]) - AW'(prod_s1[2*k+1]);
				adj_s3[k]      <= adj_s2[k];
				adj_s4[k]      <= adj_s3[k];
				adj_s5[k]      <= adj_s4[k];
			end
		end
	end

	// stages 3 and 4: row 0 expansion, cofactor split into low and high halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				mtop_s1[j] <= m_a[j];
				mtop_s2[j] <= mtop_s1[j];
				pl_s3[j]   <= mtop_s2[j] *
				              $signed({1'b0, adj_s2[DET_IDX[j]][DATA_WIDTH-1:0]});
				ph_s3[j]   <= mtop_s2[j] * $signed(adj_s2[DET_IDX[j]][AW-1:DATA_WIDTH]);
				term_s4[j] <= (TW'(ph_s3[j]) <<< DATA_WIDTH) + TW'(pl_s3[j]);
			end
		end
	end

	// stage 5: determinant sum; stage 6: signs and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5   <= DETW'(term_s4[0]) + DETW'(term_s4[1]) + DETW'(term_s4[2]);
			dneg_s6  <= det_s5[DETW-1];
			dzero_s6 <= (det_s5 == '0);
			dmag_s6  <= det_s5[DETW-1] ? (~det_s5 + 1'b1) : det_s5;
			for (int k = 0; k < 9; k++) begin
				nneg_s6[k] <= adj_s5[k][AW-1];
				nmag_s6[k] <= adj_s5[k][AW-1] ? (~adj_s5[k] + 1'b1) : adj_s5[k];
			end
		end
	end

	// singular flag follows the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[1] <= dzero_s6;
			for (int j = 2; j <= DATA_WIDTH + 2; j++) zero_s[j] <= zero_s[j-1];
		end
	end

	// nine divider lanes sharing the determinant magnitude
	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div u_div (
			.clk     (clk),
			.en      (en),
			.num_mag (nmag_s6[k]),
			.num_neg (nneg_s6[k]),
			.den_mag (dmag_s6),
			.den_neg (dneg_s6),
			.clr     (zero_s[DATA_WIDTH+1]),
			.quo     (quo[k])
		);
	end

	// output beat
	always_comb begin
		inv.inv_r0_c0 = quo[0];
		inv.inv_r0_c1 = quo[1];
		inv.inv_r0_c2 = quo[2];
		inv.inv_r1_c0 = quo[3];
		inv.inv_r1_c1 = quo[4];
		inv.inv_r1_c2 = quo[5];
		inv.inv_r2_c0 = quo[6];
		inv.inv_r2_c1 = quo[7];
		inv.inv_r2_c2 = quo[8];
		inv.singular  = zero_s[DATA_WIDTH+2];
	end

endmodule

FILE: rtl/core/mi3_chk.sv
// port-level checks for the 3x3 inverse and their binding
module mi3_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          mat_stall,
	input logic          inv_valid,
	input logic          inv_stall,
	input mi3_pkg::inv_t inv
);
	import mi3_pkg::*;

	// a stalled result beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_stall |=> inv_valid)
		else $error("result beat dropped under stall");

	// a stalled result beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_stall |=> $stable(inv))
		else $error("result payload changed under stall");

	// input side backs up exactly when a result is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall == (inv_valid && inv_stall))
		else $error("input stall does not follow output stall");

	// singular results carry zero elements
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv.singular |->
			inv.inv_r0_c0 == '0 && inv.inv_r0_c1 == '0 && inv.inv_r0_c2 == '0 &&
			inv.inv_r1_c0 == '0 && inv.inv_r1_c1 == '0 && inv.inv_r1_c2 == '0 &&
			inv.inv_r2_c0 == '0 && inv.inv_r2_c1 == '0 && inv.inv_r2_c2 == '0)
		else $error("singular result with nonzero element");

endmodule

bind matrix3_inverse mi3_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.mat_stall (mat_stall),
	.inv_valid (inv_valid),
	.inv_stall (inv_stall),
	.inv       (inv)
);

FILE: bench/tb.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse
`timescale 1ns / 100ps

module tb;
	import mi3_pkg::*;

	localparam int LATENCY = NST;
	localparam int WW = 3 * DATA_WIDTH + 2 * FRAC_BITS + 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	mat_t mat = '0;
	logic inv_valid;
	logic inv_stall = 1'b0;
	inv_t inv;

	inv_t expected_inverses[$];
	int errors = 0;
	int matrices_sent = 0;
	int inverses_seen = 0;
	int singular_seen = 0;
	int saturated_seen = 0;
	bit idle_on = 1'b1;
	bit hold_receiver = 1'b0;

	matrix3_inverse dut (
		.clk(clk),
		.arst_n(arst_n),
		.mat_valid(mat_valid),
		.mat_stall(mat_stall),
		.mat(mat),
		.inv_valid(inv_valid),
		.inv_stall(inv_stall),
		.inv(inv)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// exact quotient adj * 2^(2f) / det, truncated and saturated
	function automatic logic signed [DATA_WIDTH-1:0] scaled_quotient(
			logic signed [WW-1:0] adj, logic signed [WW-1:0] det);
		logic signed [WW-1:0] num;
		logic signed [WW-1:0] q;
		logic signed [WW-1:0] hi;
		logic signed [WW-1:0] lo;
		num = adj <<< (2 * FRAC_BITS);
		q = num / det;
		hi = (WW'(1) <<< (DATA_WIDTH - 1)) - 1;
		lo = -(WW'(1) <<< (DATA_WIDTH - 1));
		if (q > hi) begin
			saturated_seen++;
			return hi[DATA_WIDTH-1:0];
		end
		if (q < lo) begin
			saturated_seen++;
			return lo[DATA_WIDTH-1:0];
		end
		return q[DATA_WIDTH-1:0];
	endfunction

	// adjugate, determinant and expected inverse of one matrix
	function automatic inv_t invert_matrix(mat_t a);
		logic signed [WW-1:0] e[9];
		logic signed [WW-1:0] adj[9];
		logic signed [WW-1:0] det;
		logic signed [DATA_WIDTH-1:0] r[9];
		inv_t res;
		e[0] = a.in_r0_c0; e[1] = a.in_r0_c1; e[2] = a.in_r0_c2;
		e[3] = a.in_r1_c0; e[4] = a.in_r1_c1; e[5] = a.in_r1_c2;
		e[6] = a.in_r2_c0; e[7] = a.in_r2_c1; e[8] = a.in_r2_c2;
		adj[0] = e[4] * e[8] - e[5] * e[7];
		adj[1] = e[2] * e[7] - e[1] * e[8];
		adj[2] = e[1] * e[5] - e[2] * e[4];
		adj[3] = e[5] * e[6] - e[3] * e[8];
		adj[4] = e[0] * e[8] - e[2] * e[6];
		adj[5] = e[2] * e[3] - e[0] * e[5];
		adj[6] = e[3] * e[7] - e[4] * e[6];
		adj[7] = e[1] * e[6] - e[0] * e[7];
		adj[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
		res = '0;
		if (det == 0) begin
			res.singular = 1'b1;
			return res;
		end
		for (int k = 0; k < 9; k++)
			r[k] = scaled_quotient(adj[k], det);
		res.inv_r0_c0 = r[0]; res.inv_r0_c1 = r[1]; res.inv_r0_c2 = r[2];
		res.inv_r1_c0 = r[3]; res.inv_r1_c1 = r[4]; res.inv_r1_c2 = r[5];
		res.inv_r2_c0 = r[6]; res.inv_r2_c1 = r[7]; res.inv_r2_c2 = r[8];
		return res;
	endfunction

	// send one matrix beat, sometimes after an idle gap, and queue its inverse
	task automatic send_matrix(mat_t a);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			mat_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mat_valid <= 1'b1;
		mat <= a;
		@(posedge clk);
		while (mat_stall) @(posedge clk);
		expected_inverses.push_back(invert_matrix(a));
		matrices_sent++;
	endtask

	task automatic end_burst();
		mat_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		end_burst();
		while (expected_inverses.size() != 0) @(posedge clk);
	endtask

	function automatic mat_t from_elems(logic signed [DATA_WIDTH-1:0] e[9]);
		mat_t a;
		a.in_r0_c0 = e[0]; a.in_r0_c1 = e[1]; a.in_r0_c2 = e[2];
		a.in_r1_c0 = e[3]; a.in_r1_c1 = e[4]; a.in_r1_c2 = e[5];
		a.in_r2_c0 = e[6]; a.in_r2_c1 = e[7]; a.in_r2_c2 = e[8];
		return a;
	endfunction

	// element drawn from several magnitude classes
	function automatic logic signed [DATA_WIDTH-1:0] random_elem();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
			2: return $signed($urandom_range(0, 32'h1ff)) - 32'sh100;
			3: return $urandom_range(0, 1) ? 32'sh1_0000 : -32'sh1_0000;
			4: return 0;
			default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		endcase
	endfunction

	function automatic mat_t random_matrix();
		logic signed [DATA_WIDTH-1:0] e[9];
		for (int k = 0; k < 9; k++) e[k] = random_elem();
		// sometimes copy row 0 into row 2 to force a singular matrix
		if ($urandom_range(0, 7) == 0) begin
			e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
		end
		return from_elems(e);
	endfunction

	// identity, scaled, singular and extreme cases
	task automatic test_directed();
		logic signed [DATA_WIDTH-1:0] e[9];
		logic signed [DATA_WIDTH-1:0] one = 32'sh1_0000;
		e = '{one, 0, 0, 0, one, 0, 0, 0, one};
		send_matrix(from_elems(e));
		e = '{-one, 0, 0, 0, 2 * one, 0, 0, 0, one / 2};
		send_matrix(from_elems(e));
		e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(from_elems(e));
		e = '{32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 32'sh7fff_ffff};
		send_matrix(from_elems(e));
		e = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
		send_matrix(from_elems(e));
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(from_elems(e));
		e = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
		send_matrix(from_elems(e));
		e = '{0, one, 0, one, 0, 0, 0, 0, one};
		send_matrix(from_elems(e));
		e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_matrix(from_elems(e));
		e = '{2, 1, 0, 1, 2, 1, 0, 1, 2};
		send_matrix(from_elems(e));
		e = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 1, 32'sh7fff_ffff, -1,
			32'sh8000_0000, 0, 32'sh7fff_ffff};
		send_matrix(from_elems(e));
		e = '{-32'sh5555_5555, 32'sh5555_5555, 32'sh2aaa_aaaa, 32'sh5555_5555,
			-32'sh2aaa_aaab, 32'sh0f0f_0f0f, 32'sh7070_7070, 1, -32'sh1234_5678};
		send_matrix(from_elems(e));
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_matrix(random_matrix());
		end_burst();
	endtask

	// receiver holds off while matrices keep coming
	task automatic test_backpressure();
		hold_receiver = 1'b1;
		for (int i = 0; i < 3 * LATENCY; i++) send_matrix(random_matrix());
		hold_receiver = 1'b0;
		wait_drained();
	endtask

	// random receiver stalls and hold-off window
	initial begin : receiver
		int hold_cycles;
		int burst;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				inv_stall <= 1'b1;
				hold_cycles = 0;
				while (hold_receiver && hold_cycles < 4 * LATENCY) begin
					@(posedge clk);
					hold_cycles++;
				end
				inv_stall <= 1'b0;
				while (hold_receiver) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 16);
				inv_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				inv_stall <= 1'b0;
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		inv_t want;
		if (arst_n && inv_valid && !inv_stall) begin
			if (expected_inverses.size() == 0) begin
				$error("inverse beat with nothing expected");
				errors++;
			end else begin
				want = expected_inverses.pop_front();
				inverses_seen++;
				if (want.singular) singular_seen++;
				if (inv.inv_r0_c0 !== want.inv_r0_c0) begin
					$error("inv_r0_c0 exp %0d got %0d", want.inv_r0_c0, inv.inv_r0_c0);
					errors++;
				end
				if (inv.inv_r0_c1 !== want.inv_r0_c1) begin
					$error("inv_r0_c1 exp %0d got %0d", want.inv_r0_c1, inv.inv_r0_c1);
					errors++;
				end
				if (inv.inv_r0_c2 !== want.inv_r0_c2) begin
					$error("inv_r0_c2 exp %0d got %0d", want.inv_r0_c2, inv.inv_r0_c2);
					errors++;
				end
				if (inv.inv_r1_c0 !== want.inv_r1_c0) begin
					$error("inv_r1_c0 exp %0d got %0d", want.inv_r1_c0, inv.inv_r1_c0);
					errors++;
				end
				if (inv.inv_r1_c1 !== want.inv_r1_c1) begin
					$error("inv_r1_c1 exp %0d got %0d", want.inv_r1_c1, inv.inv_r1_c1);
					errors++;
				end
				if (inv.inv_r1_c2 !== want.inv_r1_c2) begin
					$error("inv_r1_c2 exp %0d got %0d", want.inv_r1_c2, inv.inv_r1_c2);
					errors++;
				end
				if (inv.inv_r2_c0 !== want.inv_r2_c0) begin
					$error("inv_r2_c0 exp %0d got %0d", want.inv_r2_c0, inv.inv_r2_c0);
					errors++;
				end
				if (inv.inv_r2_c1 !== want.inv_r2_c1) begin
					$error("inv_r2_c1 exp %0d got %0d", want.inv_r2_c1, inv.inv_r2_c1);
					errors++;
				end
				if (inv.inv_r2_c2 !== want.inv_r2_c2) begin
					$error("inv_r2_c2 exp %0d got %0d", want.inv_r2_c2, inv.inv_r2_c2);
					errors++;
				end
				if (inv.singular !== want.singular) begin
					$error("singular exp %0b got %0b", want.singular, inv.singular);
					errors++;
				end
			end
		end
	end

	// main sequence
	initial begin : stimulus
		int guard;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		test_backpressure();
		test_random(100);
		idle_on = 1'b0;
		test_random(80);
		guard = 0;
		while (expected_inverses.size() != 0 && guard < 100 * LATENCY) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (expected_inverses.size() != 0) begin
			$error("%0d inverses never arrived", expected_inverses.size());
			errors++;
		end
		$display("sent %0d matrices, checked %0d inverses", matrices_sent, inverses_seen);
		$display("%0d singular, %0d saturated elements", singular_seen, saturated_seen);
		if (errors == 0)
			$display("[matrix3_inverse] OK");
		else
			$display("[matrix3_inverse] ERROR");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#400000;
		$display("[matrix3_inverse] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_div.sv
rtl/core/matrix3_inverse.sv
rtl/core/mi3_chk.sv
bench/tb.sv
